@@ rtl/che_pkg.sv @@
// Shared types, constants and fixed-point helpers of the cubic Hermite evaluator.
`default_nettype none

package che_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CALC_WIDTH = 64;
  localparam int SPAN_WIDTH = DATA_WIDTH + 1;
  localparam int HALF_WIDTH = CALC_WIDTH / 2;
  localparam int NUM_WIDTH  = CALC_WIDTH + FRAC_BITS;
  localparam int PROD_WIDTH = CALC_WIDTH + SPAN_WIDTH;
  localparam int QUO_WIDTH  = PROD_WIDTH - FRAC_BITS;
  localparam int DIV_STEPS  = NUM_WIDTH;
  localparam int E_LAST     = 17;
  localparam int NUM_LANES  = 6;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [SPAN_WIDTH-1:0] span_t;
  typedef logic signed [CALC_WIDTH-1:0] calc_t;

  localparam logic [CALC_WIDTH-1:0] CALC_MAX_U = {1'b0, {(CALC_WIDTH-1){1'b1}}};
  localparam logic [CALC_WIDTH-1:0] CALC_MIN_U = {1'b1, {(CALC_WIDTH-1){1'b0}}};
  localparam calc_t CALC_MAX = calc_t'(CALC_MAX_U);
  localparam calc_t CALC_MIN = calc_t'(CALC_MIN_U);
  localparam calc_t DATA_MAX_C = calc_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam calc_t DATA_MIN_C = -DATA_MAX_C - calc_t'(1);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_WIDTH = 2'd1,
    ST_SATURATED  = 2'd2
  } status_t;

  typedef struct packed {
    calc_t v;
    logic  sat;
  } sres_t;

  typedef struct packed {
    data_t v;
    logic  sat;
  } fres_t;

  typedef struct packed {
    data_t y1;
    data_t s1;
    span_t u;
    span_t h;
    span_t ssum;
    calc_t d3;
    logic  zv;
    logic  zw;
    logic  sat;
  } tag_t;

  typedef struct packed {
    logic [CALC_WIDTH-1:0] ma;
    logic [SPAN_WIDTH-1:0] mb;
    logic                  neg;
  } mul0_t;

  typedef struct packed {
    logic [CALC_WIDTH-1:0] p0;
    logic [CALC_WIDTH-1:0] p1;
    logic [CALC_WIDTH-1:0] ma;
    logic                  b_top;
    logic                  neg;
  } mul1_t;

  typedef struct packed {
    logic [QUO_WIDTH-1:0] q;
    logic                 neg;
  } mul2_t;

  function automatic span_t widen(input data_t d);
    return {d[DATA_WIDTH-1], d};
  endfunction

  function automatic calc_t span_to_calc(input span_t s);
    return {{(CALC_WIDTH-SPAN_WIDTH){s[SPAN_WIDTH-1]}}, s};
  endfunction

  function automatic calc_t data_to_calc(input data_t d);
    return {{(CALC_WIDTH-DATA_WIDTH){d[DATA_WIDTH-1]}}, d};
  endfunction

  function automatic logic [CALC_WIDTH-1:0] calc_mag(input calc_t a);
    return a[CALC_WIDTH-1] ? CALC_WIDTH'(-a) : CALC_WIDTH'(a);
  endfunction

  function automatic logic [SPAN_WIDTH-1:0] span_mag(input span_t a);
    return a[SPAN_WIDTH-1] ? SPAN_WIDTH'(-a) : SPAN_WIDTH'(a);
  endfunction

  // A tag with more saturation folded into its sticky flag.
  function automatic tag_t tag_flag(input tag_t t, input logic s);
    tag_t r;
    r = t;
    r.sat = t.sat | s;
    return r;
  endfunction

  // A tag with the quotient (m - s1)/h put in its place.
  function automatic tag_t tag_with_d3(input tag_t t, input calc_t d3);
    tag_t r;
    r = t;
    r.d3 = d3;
    return r;
  endfunction

  // Saturating add and subtract on the 64-bit intermediate format.
  function automatic sres_t sat_add(input calc_t a, input calc_t b);
    calc_t s;
    sres_t r;
    s = a + b;
    r.v = s;
    r.sat = 1'b0;
    if (a[CALC_WIDTH-1] == b[CALC_WIDTH-1] && s[CALC_WIDTH-1] != a[CALC_WIDTH-1]) begin
      r.sat = 1'b1;
      r.v = a[CALC_WIDTH-1] ? CALC_MIN : CALC_MAX;
    end
    return r;
  endfunction

  function automatic sres_t sat_sub(input calc_t a, input calc_t b);
    calc_t s;
    sres_t r;
    s = a - b;
    r.v = s;
    r.sat = 1'b0;
    if (a[CALC_WIDTH-1] != b[CALC_WIDTH-1] && s[CALC_WIDTH-1] != a[CALC_WIDTH-1]) begin
      r.sat = 1'b1;
      r.v = a[CALC_WIDTH-1] ? CALC_MIN : CALC_MAX;
    end
    return r;
  endfunction

  // Applies the sign to a magnitude, saturating to the 64-bit range.
  function automatic sres_t from_mag(input logic [QUO_WIDTH-1:0] q, input logic neg);
    logic [CALC_WIDTH-1:0] lim;
    sres_t r;
    lim = neg ? CALC_MIN_U : CALC_MAX_U;
    r.sat = 1'b0;
    if (q[QUO_WIDTH-1:CALC_WIDTH] != '0 || q[CALC_WIDTH-1:0] > lim) begin
      r.sat = 1'b1;
      r.v = neg ? CALC_MIN : CALC_MAX;
    end else begin
      r.v = neg ? -calc_t'(q[CALC_WIDTH-1:0]) : calc_t'(q[CALC_WIDTH-1:0]);
    end
    return r;
  endfunction

  // Clamps an intermediate to the output field width.
  function automatic fres_t sat_field(input calc_t v);
    fres_t r;
    r.sat = 1'b0;
    r.v = v[DATA_WIDTH-1:0];
    if (v > DATA_MAX_C) begin
      r.sat = 1'b1;
      r.v = DATA_MAX_C[DATA_WIDTH-1:0];
    end else if (v < DATA_MIN_C) begin
      r.sat = 1'b1;
      r.v = DATA_MIN_C[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  // Multiplier stages: operand magnitudes, two 32x32 partial products,
  // the sum with the fraction dropped.
  function automatic mul0_t mul_prep(input calc_t a, input span_t b);
    mul0_t r;
    r.ma = calc_mag(a);
    r.mb = span_mag(b);
    r.neg = a[CALC_WIDTH-1] ^ b[SPAN_WIDTH-1];
    return r;
  endfunction

  function automatic mul1_t mul_part(input mul0_t x);
    mul1_t r;
    r.p0 = CALC_WIDTH'(x.ma[HALF_WIDTH-1:0]) * CALC_WIDTH'(x.mb[HALF_WIDTH-1:0]);
    r.p1 = CALC_WIDTH'(x.ma[CALC_WIDTH-1:HALF_WIDTH]) * CALC_WIDTH'(x.mb[HALF_WIDTH-1:0]);
    r.ma = x.ma;
    r.b_top = x.mb[SPAN_WIDTH-1];
    r.neg = x.neg;
    return r;
  endfunction

  function automatic mul2_t mul_sum(input mul1_t x);
    logic [PROD_WIDTH-1:0] p;
    mul2_t r;
    p = PROD_WIDTH'(x.p0) + (PROD_WIDTH'(x.p1) << HALF_WIDTH)
      + (x.b_top ? (PROD_WIDTH'(x.ma) << HALF_WIDTH) : '0);
    r.q = p[PROD_WIDTH-1:FRAC_BITS];
    r.neg = x.neg;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/che_if.sv @@
// Valid/ready channel interfaces for query and result beats.
`default_nettype none

interface che_in_if import che_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t left_knot;
  data_t right_knot;
  data_t left_value;
  data_t right_value;
  data_t left_slope;
  data_t right_slope;
  data_t query_point;

  modport source(output valid, left_knot, right_knot, left_value, right_value,
                 left_slope, right_slope, query_point, input ready);
  modport sink(input valid, left_knot, right_knot, left_value, right_value,
               left_slope, right_slope, query_point, output ready);
endinterface

interface che_out_if import che_pkg::*; ();
  logic       valid;
  logic       ready;
  data_t      value_out;
  data_t      slope_out;
  logic [1:0] status;

  modport source(output valid, value_out, slope_out, status, input ready);
  modport sink(input valid, value_out, slope_out, status, output ready);
endinterface

`default_nettype wire

@@ rtl/che_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
`default_nettype none

module che_div import che_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  calc_t num,
  input  span_t den,
  input  tag_t  in_tag,
  output logic  out_valid,
  output sres_t quo,
  output tag_t  out_tag
);

  logic [DIV_STEPS:0]    vld;
  logic [SPAN_WIDTH-1:0] dvs [0:DIV_STEPS];
  logic [NUM_WIDTH-1:0]  nq [0:DIV_STEPS];
  logic                  ng [0:DIV_STEPS];
  tag_t                  tg [0:DIV_STEPS];
  logic [SPAN_WIDTH-1:0] rem [1:DIV_STEPS];
  logic [SPAN_WIDTH-1:0] rem_next [1:DIV_STEPS];
  logic [NUM_WIDTH-1:0]  nq_next [1:DIV_STEPS];

  // Each stage shifts one dividend bit into the remainder and retires one
  // quotient bit into the low end of the same shift word.
  always_comb begin
    logic [SPAN_WIDTH-1:0] prev;
    logic [SPAN_WIDTH:0]   trial;
    logic                  qb;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      prev = (k == 1) ? '0 : rem[k-1];
      trial = {prev, nq[k-1][NUM_WIDTH-1]};
      if (trial >= {1'b0, dvs[k-1]}) begin
        rem_next[k] = SPAN_WIDTH'(trial - {1'b0, dvs[k-1]});
        qb = 1'b1;
      end else begin
        rem_next[k] = trial[SPAN_WIDTH-1:0];
        qb = 1'b0;
      end
      nq_next[k] = {nq[k-1][NUM_WIDTH-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS-1:0], in_valid};
      out_valid <= vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq[0] <= {calc_mag(num), {FRAC_BITS{1'b0}}};
      dvs[0] <= span_mag(den);
      ng[0] <= num[CALC_WIDTH-1] ^ den[SPAN_WIDTH-1];
      tg[0] <= in_tag;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        rem[k] <= rem_next[k];
        nq[k] <= nq_next[k];
        dvs[k] <= dvs[k-1];
        ng[k] <= ng[k-1];
        tg[k] <= tg[k-1];
      end
      if (dvs[DIV_STEPS] == '0) begin
        quo <= '0;
      end else begin
        quo <= from_mag(QUO_WIDTH'(nq[DIV_STEPS]), ng[DIV_STEPS]);
      end
      out_tag <= tg[DIV_STEPS];
    end
  end

endmodule

`default_nettype wire

@@ rtl/cubic_hermite_evaluator.sv @@
// Cubic Hermite interval evaluator: value and slope at a query point, Q16.16.
// Most of the depth from an accepted query beat to its result beat lies in
// three chained divider levels, each divider with 80 quotient-bit stages
// between an input and an output register.
// Throughput is one beat per cycle; a stalled output freezes the whole pipeline.
// Synchronous reset clears only the valid bits; payload registers are not reset.
`default_nettype none

module cubic_hermite_evaluator import che_pkg::*; (
  input logic clk,
  input logic rst,
  che_in_if.sink query,
  che_out_if.source result
);

  // The whole pipeline moves together. It advances whenever the output
  // register is empty or its beat is being taken, so no new query beat can
  // be accepted while an earlier result waits untaken.
  logic adv;
  logic res_valid;

  assign adv = !res_valid || result.ready;
  assign query.ready = adv;

  // Input register.
  logic  p0_v;
  data_t x1, x2, y1, y2, s1, s2, xq;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
    end else if (adv) begin
      p0_v <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1 <= query.left_knot;
      x2 <= query.right_knot;
      y1 <= query.left_value;
      y2 <= query.right_value;
      s1 <= query.left_slope;
      s2 <= query.right_slope;
      xq <= query.query_point;
    end
  end

  // Interval width, value step, query offset, slope sum and zero flags.
  // The 33-bit sums and differences of 32-bit fields are exact, so nothing saturates.
  logic  p1_v;
  tag_t  p1_tag;
  span_t p1_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (adv) begin
      p1_v <= p0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_tag.y1 <= y1;
      p1_tag.s1 <= s1;
      p1_tag.u <= widen(xq) - widen(x1);
      p1_tag.h <= widen(x2) - widen(x1);
      p1_tag.ssum <= widen(s1) + widen(s2);
      p1_tag.d3 <= '0;
      p1_tag.zv <= (y1 == '0) && (y2 == '0);
      p1_tag.zw <= (x1 == x2);
      p1_tag.sat <= 1'b0;
      p1_dy <= widen(y2) - widen(y1);
    end
  end

  // First divider: the secant slope m = (y2 - y1) / h.
  logic  d1_v;
  sres_t d1_q;
  tag_t  d1_tag;

  che_div u_div_m (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (p1_v),
    .num       (span_to_calc(p1_dy)),
    .den       (p1_tag.h),
    .in_tag    (p1_tag),
    .out_valid (d1_v),
    .quo       (d1_q),
    .out_tag   (d1_tag)
  );

  // Numerators of the next two divisions. The secant slope stays below
  // 2^48, so these sums are exact in 64 bits.
  logic  b_v;
  tag_t  b_tag;
  calc_t b_num1, b_num3;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_tag <= tag_flag(d1_tag, d1_q.sat);
      b_num1 <= span_to_calc(d1_tag.ssum) - (d1_q.v + d1_q.v);
      b_num3 <= d1_q.v - data_to_calc(d1_tag.s1);
    end
  end

  // Second level: the first division of the cubic coefficient and (m - s1)/h
  // run side by side; only the first one carries the tag.
  logic  d2_v;
  sres_t d2_q, d3_div;
  tag_t  d2_tag;

  che_div u_div_c4a (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (b_v),
    .num       (b_num1),
    .den       (b_tag.h),
    .in_tag    (b_tag),
    .out_valid (d2_v),
    .quo       (d2_q),
    .out_tag   (d2_tag)
  );

  che_div u_div_d3 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (b_v),
    .num       (b_num3),
    .den       (b_tag.h),
    .in_tag    ('0),
    .out_valid (),
    .quo       (d3_div),
    .out_tag   ()
  );

  logic  c_v;
  tag_t  c_tag;
  calc_t c_c4a;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_tag <= tag_flag(tag_with_d3(d2_tag, d3_div.v), d2_q.sat | d3_div.sat);
      c_c4a <= d2_q.v;
    end
  end

  // Third level: the cubic coefficient c4.
  logic  d4_v;
  sres_t c4;
  tag_t  d4_tag;

  che_div u_div_c4 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (c_v),
    .num       (c_c4a),
    .den       (c_tag.h),
    .in_tag    (c_tag),
    .out_valid (d4_v),
    .quo       (c4),
    .out_tag   (d4_tag)
  );

  // Evaluation pipeline. Stage k holds etag[k]; the stages where a sum or a
  // product lands add to the sticky saturation flag of the item they pass on.
  logic [E_LAST:0] ev;
  tag_t            etag [0:E_LAST];
  logic [E_LAST:0] ss;

  // Six multiplier lanes, each four registers deep. Lanes 0 to 2 take
  // c4*h, u*c4 and u*3c4 at the same time; lanes 3 and 4 take u*w1 and
  // u*q2; lane 5 takes u*w2.
  mul0_t m0 [0:NUM_LANES-1];
  mul1_t m1 [0:NUM_LANES-1];
  mul2_t m2 [0:NUM_LANES-1];
  sres_t mr [0:NUM_LANES-1];
  calc_t lane_a [0:NUM_LANES-1];
  span_t lane_b [0:NUM_LANES-1];

  calc_t c4_e0, t_e0;
  calc_t c3_e5, rb_e5, rc_e5;
  calc_t w1_e6, c32_e6, rc_e6;
  calc_t w1_e7, q2_e7;
  calc_t w2_e12;
  calc_t slp_e [0:4];
  calc_t val_e17, slp_e17;

  sres_t ta, tb, c3, w1, c32, q2, w2, slp, val;

  always_comb begin
    ta = sat_add(c4.v, c4.v);
    tb = sat_add(ta.v, c4.v);
    c3 = sat_sub(etag[4].d3, mr[0].v);
    w1 = sat_add(c3_e5, rb_e5);
    c32 = sat_add(c3_e5, c3_e5);
    q2 = sat_add(c32_e6, rc_e6);
    w2 = sat_add(data_to_calc(etag[11].s1), mr[3].v);
    slp = sat_add(data_to_calc(etag[11].s1), mr[4].v);
    val = sat_add(data_to_calc(etag[16].y1), mr[5].v);

    ss = '0;
    ss[0] = c4.sat | ta.sat | tb.sat;
    ss[5] = mr[0].sat | mr[1].sat | mr[2].sat | c3.sat;
    ss[6] = w1.sat | c32.sat;
    ss[7] = q2.sat;
    ss[12] = mr[3].sat | mr[4].sat | w2.sat | slp.sat;
    ss[17] = mr[5].sat | val.sat;

    lane_a[0] = c4_e0;  lane_b[0] = etag[0].h;
    lane_a[1] = c4_e0;  lane_b[1] = etag[0].u;
    lane_a[2] = t_e0;   lane_b[2] = etag[0].u;
    lane_a[3] = w1_e7;  lane_b[3] = etag[7].u;
    lane_a[4] = q2_e7;  lane_b[4] = etag[7].u;
    lane_a[5] = w2_e12; lane_b[5] = etag[12].u;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= '0;
    end else if (adv) begin
      ev <= {ev[E_LAST-1:0], d4_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      etag[0] <= tag_flag(d4_tag, ss[0]);
      for (int k = 1; k <= E_LAST; k++) begin
        etag[k] <= tag_flag(etag[k-1], ss[k]);
      end

      for (int j = 0; j < NUM_LANES; j++) begin
        m0[j] <= mul_prep(lane_a[j], lane_b[j]);
        m1[j] <= mul_part(m0[j]);
        m2[j] <= mul_sum(m1[j]);
        mr[j] <= from_mag(m2[j].q, m2[j].neg);
      end

      c4_e0 <= c4.v;
      t_e0 <= tb.v;
      c3_e5 <= c3.v;
      rb_e5 <= mr[1].v;
      rc_e5 <= mr[2].v;
      w1_e6 <= w1.v;
      c32_e6 <= c32.v;
      rc_e6 <= rc_e5;
      w1_e7 <= w1_e6;
      q2_e7 <= q2.v;
      w2_e12 <= w2.v;
      slp_e[0] <= slp.v;
      for (int k = 1; k < 5; k++) begin
        slp_e[k] <= slp_e[k-1];
      end
      val_e17 <= val.v;
      slp_e17 <= slp_e[4];
    end
  end

  // Output register: clamp to the field width and pick the status. Equal
  // knot values of zero win over a zero-width interval.
  fres_t   fv, fs;
  data_t   res_value, res_slope;
  status_t res_status;

  assign fv = sat_field(val_e17);
  assign fs = sat_field(slp_e17);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= ev[E_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (etag[E_LAST].zv) begin
        res_value <= '0;
        res_slope <= '0;
        res_status <= ST_OK;
      end else if (etag[E_LAST].zw) begin
        res_value <= '0;
        res_slope <= '0;
        res_status <= ST_ZERO_WIDTH;
      end else begin
        res_value <= fv.v;
        res_slope <= fs.v;
        res_status <= (etag[E_LAST].sat | fv.sat | fs.sat) ? ST_SATURATED : ST_OK;
      end
    end
  end

  assign result.valid = res_valid;
  assign result.value_out = res_value;
  assign result.slope_out = res_slope;
  assign result.status = res_status;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench of the cubic Hermite evaluator, with a Q16.16 predictor.
`timescale 1ns / 100ps

module tb_top;
  import che_pkg::*;

  // The pipeline freezes while the output stalls. The watchdog limit covers
  // the pipeline latency, the longest idle gap on either side, and the drain
  // at the end, with a wide margin.
  localparam int LATENCY      = 269;
  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_ITEMS = 1040;
  localparam int MAX_REPORTS  = 10;

  localparam calc_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam calc_t Q_MIN = 64'sh8000_0000_0000_0000;
  localparam calc_t FIELD_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam calc_t FIELD_MIN = -64'sh0000_0000_8000_0000;

  // One query beat: an interval, its end values and slopes, and a point.
  typedef struct {
    data_t x1;
    data_t x2;
    data_t y1;
    data_t y2;
    data_t s1;
    data_t s2;
    data_t xq;
  } query_t;

  // One result beat as it should leave the block.
  typedef struct {
    data_t   value;
    data_t   slope;
    status_t status;
  } answer_t;

  // A row of the directed table. Rows with a typed-in answer are checked
  // against it; the others go through the predictor.
  typedef struct {
    query_t  q;
    bit      typed;
    answer_t ans;
  } row_t;

  logic clk;
  logic rst;

  che_in_if  qch();
  che_out_if rch();

  cubic_hermite_evaluator DUT (
    .clk   (clk),
    .rst   (rst),
    .query (qch),
    .result(rch)
  );

  answer_t pending_answers[$];
  int      mismatches;
  int      idle_cycles;
  bit      sender_done;
  bit      clamp_seen;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Fixed-point predictor. Every intermediate is a signed 64-bit number
  // with 16 fraction bits; any clamp along the way sets clamp_seen.
  // ---------------------------------------------------------------------
  function automatic logic [63:0] abs64(input calc_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // Signs a 128-bit magnitude and clamps it to the 64-bit range.
  function automatic calc_t signed_clamp(input logic [127:0] m, input bit neg);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
    if (m > lim) begin
      clamp_seen = 1'b1;
      return neg ? Q_MIN : Q_MAX;
    end
    return neg ? -calc_t'(m[63:0]) : calc_t'(m[63:0]);
  endfunction

  function automatic calc_t q_add(input calc_t a, input calc_t b);
    calc_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      clamp_seen = 1'b1;
      return a[63] ? Q_MIN : Q_MAX;
    end
    return s;
  endfunction

  function automatic calc_t q_sub(input calc_t a, input calc_t b);
    calc_t s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) begin
      clamp_seen = 1'b1;
      return a[63] ? Q_MIN : Q_MAX;
    end
    return s;
  endfunction

  // Exact product, fraction bits dropped from the magnitude.
  function automatic calc_t q_mul(input calc_t a, input calc_t b);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    return signed_clamp(p >> FRAC_BITS, a[63] ^ b[63]);
  endfunction

  // Quotient of magnitudes, truncated; a zero divisor gives zero.
  function automatic calc_t q_div(input calc_t a, input calc_t b);
    logic [127:0] num;
    logic [127:0] den;
    den = {64'd0, abs64(b)};
    if (den == 128'd0) return '0;
    num = {64'd0, abs64(a)} << FRAC_BITS;
    return signed_clamp(num / den, a[63] ^ b[63]);
  endfunction

  function automatic data_t to_field(input calc_t v);
    if (v > FIELD_MAX) begin
      clamp_seen = 1'b1;
      return data_t'(FIELD_MAX);
    end
    if (v < FIELD_MIN) begin
      clamp_seen = 1'b1;
      return data_t'(FIELD_MIN);
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  function automatic answer_t hermite_eval(input query_t q);
    answer_t a;
    calc_t x1, x2, y1, y2, s1, s2, xq;
    calc_t h, m, c3, c4, u, val, slp, c4x3;
    x1 = calc_t'(q.x1);
    x2 = calc_t'(q.x2);
    y1 = calc_t'(q.y1);
    y2 = calc_t'(q.y2);
    s1 = calc_t'(q.s1);
    s2 = calc_t'(q.s2);
    xq = calc_t'(q.xq);
    clamp_seen = 1'b0;
    a.value  = '0;
    a.slope  = '0;
    a.status = ST_OK;
    // Both end values zero: the result is zero whatever the knots are.
    if (y1 == 0 && y2 == 0) return a;
    // A zero-width interval is an error with zero results.
    if (x1 == x2) begin
      a.status = ST_ZERO_WIDTH;
      return a;
    end
    h  = q_sub(x2, x1);
    m  = q_div(q_sub(y2, y1), h);
    c4 = q_div(q_div(q_sub(q_add(s1, s2), q_add(m, m)), h), h);
    c3 = q_sub(q_div(q_sub(m, s1), h), q_mul(c4, h));
    u  = q_sub(xq, x1);
    val  = q_add(y1, q_mul(u, q_add(s1, q_mul(u, q_add(c3, q_mul(u, c4))))));
    c4x3 = q_add(q_add(c4, c4), c4);
    slp  = q_add(s1, q_mul(u, q_add(q_add(c3, c3), q_mul(u, c4x3))));
    a.value  = to_field(val);
    a.slope  = to_field(slp);
    a.status = clamp_seen ? ST_SATURATED : ST_OK;
    return a;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  function automatic query_t mk_query(input data_t x1, input data_t x2, input data_t y1,
                                      input data_t y2, input data_t s1, input data_t s2,
                                      input data_t xq);
    query_t q;
    q.x1 = x1; q.x2 = x2; q.y1 = y1; q.y2 = y2;
    q.s1 = s1; q.s2 = s2; q.xq = xq;
    return q;
  endfunction

  // Uniform value in [-span, span]; span stays below 2**30.
  function automatic data_t rand_span(input int unsigned span);
    return data_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  function automatic data_t rand_word();
    return data_t'($urandom());
  endfunction

  // Most random queries are well-formed intervals of moderate size, so that
  // the arithmetic stays out of saturation; the rest are raw words, zero
  // values, zero widths and very narrow intervals that drive it to clamp.
  function automatic query_t rand_query();
    query_t q;
    int unsigned pick;
    int unsigned width;
    pick = $urandom_range(0, 99);
    q.x1 = rand_span(32'd100 << 16);
    width = $urandom_range(1, 32'd8 << 16);
    q.x2 = ($urandom_range(0, 7) == 0) ? q.x1 - data_t'(width) : q.x1 + data_t'(width);
    q.y1 = rand_span(32'd1000 << 16);
    q.y2 = rand_span(32'd1000 << 16);
    q.s1 = rand_span(32'd50 << 16);
    q.s2 = rand_span(32'd50 << 16);
    q.xq = q.x1 + rand_span(width + (width >> 2));
    if (pick >= 60 && pick < 80) begin
      q = mk_query(rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word(), rand_word());
    end else if (pick >= 80 && pick < 87) begin
      q.y1 = '0;
      q.y2 = '0;
      if ($urandom_range(0, 1) == 1) q.x2 = q.x1;
    end else if (pick >= 87 && pick < 94) begin
      q.x2 = q.x1;
      if ($urandom_range(0, 1) == 1) q.y1 = rand_word();
    end else if (pick >= 94) begin
      q.x2 = q.x1 + data_t'($urandom_range(1, 16));
      q.y1 = rand_word();
      q.y2 = rand_word();
      q.s1 = rand_word();
    end
    return q;
  endfunction

  // Idle cycles before a beat; some stretches run with no idling at all.
  function automatic int draw_gap(input bit eager);
    if (eager) return 0;
    return $urandom_range(0, 17);
  endfunction

  // ---------------------------------------------------------------------
  // Query side.
  // ---------------------------------------------------------------------
  row_t table_rows[$];

  task automatic add_row(input query_t q, input bit typed, input data_t v, input data_t s,
                         input status_t st);
    row_t r;
    r.q = q;
    r.typed = typed;
    r.ans.value = v;
    r.ans.slope = s;
    r.ans.status = st;
    table_rows.push_back(r);
  endtask

  task automatic build_table();
    // Both values zero, ordinary and extreme knots, and also zero width.
    add_row(mk_query(0, 0, 0, 0, 0, 0, 0), 1, 0, 0, ST_OK);
    add_row(mk_query(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_FFFF,
                     32'sh8000_0000, 32'sh7FFF_FFFF), 1, 0, 0, ST_OK);
    add_row(mk_query(32'sh0001_0000, 32'sh0001_0000, 0, 0, 32'sh0001_0000,
                     32'sh0001_0000, 0), 1, 0, 0, ST_OK);
    // Zero-width intervals with nonzero values.
    add_row(mk_query(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0,
                     32'sh0000_8000), 1, 0, 0, ST_ZERO_WIDTH);
    add_row(mk_query(32'sh8000_0000, 32'sh8000_0000, 0, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000), 1, 0, 0, ST_ZERO_WIDTH);
    add_row(mk_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                     -1, -1, -1), 1, 0, 0, ST_ZERO_WIDTH);
    // Ordinary intervals, inside and outside the knots.
    add_row(mk_query(0, 32'sh0001_0000, 0, 32'sh0001_0000, 0, 0, 32'sh0000_8000),
            0, 0, 0, ST_OK);
    add_row(mk_query(0, 32'sh0001_0000, 0, 32'sh0001_0000, 32'sh0001_0000,
                     32'sh0001_0000, 32'sh0000_4000), 0, 0, 0, ST_OK);
    add_row(mk_query(32'shFFFE_0000, 32'sh0003_0000, 32'sh0002_0000, 32'shFFFF_0000,
                     32'sh0000_8000, 32'shFFFF_8000, 32'sh0004_0000), 0, 0, 0, ST_OK);
    add_row(mk_query(32'sh0005_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0003_0000,
                     32'sh0002_0000, 32'shFFFD_0000, 32'sh0003_8000), 0, 0, 0, ST_OK);
    // Extreme, tiny-width and patterned fields, meant to drive the arithmetic to clamp.
    add_row(mk_query(0, 32'sh0001_0000, 0, 32'sh0001_0000, 0, 0, 32'sh7FFF_FFFF),
            0, 0, 0, ST_OK);
    add_row(mk_query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000), 0, 0, 0, ST_OK);
    add_row(mk_query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                     32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF), 0, 0, 0, ST_OK);
    add_row(mk_query(0, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 1), 0, 0, 0, ST_OK);
    add_row(mk_query(0, 1, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF, 0), 0, 0, 0, ST_OK);
    add_row(mk_query(-1, -2, -1, -1, -1, -1, -1), 0, 0, 0, ST_OK);
    add_row(mk_query(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                     32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555), 0, 0, 0, ST_OK);
    add_row(mk_query(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                     32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA), 0, 0, 0, ST_OK);
  endtask

  // Drives one query beat and waits for its handshake. The valid line is
  // lowered only when a gap follows, so back-to-back beats keep it high.
  task automatic send_query(input query_t q, input answer_t ans, input int gap);
    if (gap > 0) begin
      qch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    qch.valid       <= 1'b1;
    qch.left_knot   <= q.x1;
    qch.right_knot  <= q.x2;
    qch.left_value  <= q.y1;
    qch.right_value <= q.y2;
    qch.left_slope  <= q.s1;
    qch.right_slope <= q.s2;
    qch.query_point <= q.xq;
    do @(posedge clk); while (!qch.ready);
    pending_answers.push_back(ans);
  endtask

  initial begin
    query_t  q;
    answer_t ans;
    bit      eager;
    rst             <= 1'b1;
    sender_done     = 1'b0;
    qch.valid       <= 1'b0;
    qch.left_knot   <= '0;
    qch.right_knot  <= '0;
    qch.left_value  <= '0;
    qch.right_value <= '0;
    qch.left_slope  <= '0;
    qch.right_slope <= '0;
    qch.query_point <= '0;
    build_table();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (table_rows[i]) begin
      ans = table_rows[i].typed ? table_rows[i].ans : hermite_eval(table_rows[i].q);
      send_query(table_rows[i].q, ans, draw_gap(i < 8));
    end

    // Random queries. Every 64 beats the sender redraws whether it runs an eager
    // or an idling stretch; halfway through it lets the pipeline drain fully.
    eager = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) eager = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_ITEMS / 2) begin
        qch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
      end
      q = rand_query();
      send_query(q, hermite_eval(q), draw_gap(eager));
    end
    qch.valid <= 1'b0;
    sender_done = 1'b1;
  end

  // ---------------------------------------------------------------------
  // Result side: random stalls, then a field-by-field compare against the
  // oldest outstanding answer, or a report of a beat with none outstanding.
  // ---------------------------------------------------------------------
  initial begin
    answer_t want;
    int      stall;
    bit      eager;
    mismatches = 0;
    rch.ready <= 1'b0;
    eager = 1'b0;
    @(negedge rst);
    for (int n = 0; ; n++) begin
      if (n % 50 == 0) eager = ($urandom_range(0, 2) == 0);
      stall = draw_gap(eager);
      if (stall > 0) begin
        rch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rch.ready <= 1'b1;
      do @(posedge clk); while (!rch.valid);
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: value %h slope %h status %0d",
                   rch.value_out, rch.slope_out, rch.status);
      end else begin
        want = pending_answers.pop_front();
        if (rch.value_out !== want.value || rch.slope_out !== want.slope ||
            rch.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: value %h/%h slope %h/%h status %0d/%0d (exp/act)",
                     want.value, rch.value_out, want.slope, rch.slope_out,
                     want.status, rch.status);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (qch.valid && qch.ready) || (rch.valid && rch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // End of run: all queries sent, all answers in, then a drain period that
  // would expose any extra result beat.
  initial begin
    wait (sender_done);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (LATENCY + 40) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ cubic_hermite_evaluator.f @@
rtl/che_pkg.sv
rtl/che_if.sv
rtl/che_div.sv
rtl/cubic_hermite_evaluator.sv
sim/tb_top.sv
